// ===== rtl/lrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and helpers for the LPM route table
// Holds the operation and status codes, the broadcast item, the token that
// walks the cell chain, and the prefix mask helper.
// ----------------------------------------------------------------------------
package lrt_pkg;

    // Default number of route slots, one cell per slot.
    localparam int LRT_TABLE_DEPTH = 32;

    // Field widths fixed by the interface.
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int PORT_W   = 8;
    localparam int METRIC_W = 5;
    localparam int STATUS_W = 2;

    // Longest legal prefix; longer lengths are clamped to it.
    localparam logic [LEN_W-1:0]  FULL_LEN = LEN_W'(32);
    localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_UNUSED = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Item fields, held by the top level and seen by every cell.
    typedef struct packed {
        t_func                func;
        logic [ADDR_W-1:0]    addr;
        logic [LEN_W-1:0]     len;
        logic [PORT_W-1:0]    port;
        logic [ADDR_W-1:0]    next_hop;
        logic [METRIC_W-1:0]  metric;
    } t_item;

    // Search token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                 live;
        logic                 hit;
        logic                 free_found;
        logic                 best_found;
        logic [LEN_W-1:0]     best_len;
        logic [ADDR_W-1:0]    best_nh;
        logic [PORT_W-1:0]    best_port;
        logic [METRIC_W-1:0]  best_metric;
    } t_tok;

    // Mask covering the low len bits of an address.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len >= FULL_LEN) begin
            m = '1;
        end else begin
            m = (ADDR_ONE << len) - ADDR_ONE;
        end
        return m;
    endfunction

endpackage

// ===== rtl/lrt_cell.sv =====
// ----------------------------------------------------------------------------
// lrt_cell: one route slot of the chain
// Stores one route, checks the passing token against it, updates the token
// and the slot, and hands the token to the next cell on the following cycle.
// ----------------------------------------------------------------------------
module lrt_cell
    import lrt_pkg::*;
#(
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_tok             i_tok,
    input  logic [IDX_W-1:0] i_free_idx,
    output t_tok             o_tok,
    output logic [IDX_W-1:0] o_free_idx
);

    logic                r_vld, n_vld;
    logic [ADDR_W-1:0]   r_prefix, n_prefix;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [ADDR_W-1:0]   r_nh, n_nh;
    logic [PORT_W-1:0]   r_port, n_port;
    logic [METRIC_W-1:0] r_metric, n_metric;
    t_tok                r_tok, n_tok;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;

    logic                exact;
    logic                covers;
    logic [ADDR_W-1:0]   mask;

    // Compare the slot against the item.
    always_comb begin
        mask   = len_mask(r_len);
        exact  = r_vld && (r_prefix == i_item.addr) && (r_len == i_item.len);
        covers = r_vld && (((i_item.addr ^ r_prefix) & mask) == '0);
    end

    // Token update and slot write.
    always_comb begin
        n_tok      = i_tok;
        n_free_idx = i_free_idx;
        n_vld      = r_vld;
        n_prefix   = r_prefix;
        n_len      = r_len;
        n_nh       = r_nh;
        n_port     = r_port;
        n_metric   = r_metric;

        // A new route is placed here once the search has picked this slot.
        if (i_wr_en && (i_wr_idx == IDX_W'(CELL_IDX))) begin
            n_vld    = 1'b1;
            n_prefix = i_item.addr;
            n_len    = i_item.len;
            n_nh     = i_item.next_hop;
            n_port   = i_item.port;
            n_metric = i_item.metric;
        end

        if (i_tok.live) begin
            case (i_item.func)
                FN_INSERT: begin
                    if (exact && !i_tok.hit) begin
                        n_tok.hit = 1'b1;
                        n_nh      = i_item.next_hop;
                        n_port    = i_item.port;
                        n_metric  = i_item.metric;
                    end
                    if (!r_vld && !i_tok.free_found) begin
                        n_tok.free_found = 1'b1;
                        n_free_idx       = IDX_W'(CELL_IDX);
                    end
                end
                FN_DELETE: begin
                    if (exact && !i_tok.hit) begin
                        n_tok.hit = 1'b1;
                        n_vld     = 1'b0;
                    end
                end
                FN_LOOKUP: begin
                    // Strictly longer wins, so the lowest slot keeps a tie.
                    if (covers && (!i_tok.best_found || (r_len > i_tok.best_len))) begin
                        n_tok.best_found  = 1'b1;
                        n_tok.best_len    = r_len;
                        n_tok.best_nh     = r_nh;
                        n_tok.best_port   = r_port;
                        n_tok.best_metric = r_metric;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Slot and token registers; only the slot valid bit and the token live bit take reset.
    always_ff @(posedge i_clk) begin
        r_prefix          <= n_prefix;
        r_len             <= n_len;
        r_nh              <= n_nh;
        r_port            <= n_port;
        r_metric          <= n_metric;
        r_tok.hit         <= n_tok.hit;
        r_tok.free_found  <= n_tok.free_found;
        r_tok.best_found  <= n_tok.best_found;
        r_tok.best_len    <= n_tok.best_len;
        r_tok.best_nh     <= n_tok.best_nh;
        r_tok.best_port   <= n_tok.best_port;
        r_tok.best_metric <= n_tok.best_metric;
        r_free_idx        <= n_free_idx;
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_tok.live <= 1'b0;
        end else begin
            r_vld      <= n_vld;
            r_tok.live <= n_tok.live;
        end
    end

    assign o_tok      = r_tok;
    assign o_free_idx = r_free_idx;

endmodule

// ===== rtl/lpm_route_table.sv =====
// ----------------------------------------------------------------------------
// lpm_route_table: IPv4 longest-prefix-match route table
// A chain of route cells searched by a token that moves one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
// A command beat (insert, delete or lookup) is taken at a rising edge where
// start is high and busy is low. busy then stays high until the result beat
// is shown. Each command gives exactly one result beat, shown for one cycle
// with o_valid high; the receiver cannot stall it, so it must take it then.
// The search token is launched into the head of the chain, walks it one route
// cell per cycle and sets the registered result beat as it leaves the tail; a
// new command can be taken in the cycle that shows the result, so only one
// command is ever walking the chain. An insert of a new route writes its chosen
// slot in the cycle after the search, which overlaps the next command's start.
// Reset (synchronous, active low) empties the table at once: every slot's
// valid bit is cleared, with no clearing pass.
// ----------------------------------------------------------------------------
module lpm_route_table
    import lrt_pkg::*;
#(
    parameter int TABLE_DEPTH = LRT_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_func,
    input  logic [ADDR_W-1:0]   i_prefix_addr,
    input  logic [LEN_W-1:0]    i_prefix_len,
    input  logic [PORT_W-1:0]   i_port,
    input  logic [ADDR_W-1:0]   i_next_hop,
    input  logic [METRIC_W-1:0] i_hop_metric,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ADDR_W-1:0]   o_out_next_hop,
    output logic [PORT_W-1:0]   o_out_port,
    output logic [METRIC_W-1:0] o_out_metric
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_item               r_item;
    logic                r_busy, r_launch, r_wr_en;
    logic [IDX_W-1:0]    r_wr_idx;
    logic                r_out_valid;
    t_status             r_status;
    logic [ADDR_W-1:0]   r_out_nh;
    logic [PORT_W-1:0]   r_out_port;
    logic [METRIC_W-1:0] r_out_metric;

    logic                accept;
    t_tok                head_tok;
    t_tok                w_tok [0:TABLE_DEPTH];
    logic [IDX_W-1:0]    w_idx [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_live;
    t_tok                last_tok;
    logic                place;

    assign accept = start && !r_busy;

    // Capture the command beat, clamping the prefix length.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.func     <= t_func'(i_func);
            r_item.addr     <= i_prefix_addr;
            r_item.len      <= (i_prefix_len > FULL_LEN) ? FULL_LEN : i_prefix_len;
            r_item.port     <= i_port;
            r_item.next_hop <= i_next_hop;
            r_item.metric   <= i_hop_metric;
        end
    end

    // Fresh token entering the head of the chain.
    always_comb begin
        head_tok      = '0;
        head_tok.live = r_launch;
    end

    assign w_tok[0] = head_tok;
    assign w_idx[0] = '0;

    // The chain of route cells.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        lrt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_item     (r_item),
            .i_wr_en    (r_wr_en),
            .i_wr_idx   (r_wr_idx),
            .i_tok      (w_tok[g]),
            .i_free_idx (w_idx[g]),
            .o_tok      (w_tok[g+1]),
            .o_free_idx (w_idx[g+1])
        );
        assign w_live[g] = w_tok[g+1].live;
    end

    assign last_tok = w_tok[TABLE_DEPTH];
    assign place    = (r_item.func == FN_INSERT) && !last_tok.hit && last_tok.free_found;

    // Control: busy span, token launch, result valid and the deferred slot write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_launch    <= 1'b0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch    <= accept;
            r_wr_en     <= last_tok.live && place;
            r_out_valid <= last_tok.live;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last_tok.live) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Result beat from the token leaving the tail of the chain.
    always_ff @(posedge i_clk) begin
        r_wr_idx <= w_idx[TABLE_DEPTH];
        if (last_tok.live) begin
            case (r_item.func)
                FN_INSERT: begin
                    r_status     <= (last_tok.hit || last_tok.free_found) ? ST_DONE : ST_FULL;
                    r_out_nh     <= '0;
                    r_out_port   <= '0;
                    r_out_metric <= '0;
                end
                FN_DELETE: begin
                    r_status     <= last_tok.hit ? ST_DONE : ST_MISS;
                    r_out_nh     <= '0;
                    r_out_port   <= '0;
                    r_out_metric <= '0;
                end
                FN_LOOKUP: begin
                    // The best fields start at zero and stay so without a match.
                    r_status     <= last_tok.best_found ? ST_DONE : ST_MISS;
                    r_out_nh     <= last_tok.best_nh;
                    r_out_port   <= last_tok.best_port;
                    r_out_metric <= last_tok.best_metric;
                end
                default: begin
                    r_status     <= ST_MISS;
                    r_out_nh     <= '0;
                    r_out_port   <= '0;
                    r_out_metric <= '0;
                end
            endcase
        end
    end

    assign busy           = r_busy;
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_next_hop = r_out_nh;
    assign o_out_port     = r_out_port;
    assign o_out_metric   = r_out_metric;

`ifndef NO_ASSERTIONS
    // Only one command is ever walking the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_live, r_launch}) <= 1)
        else $error("more than one search token in the chain");

    // The token leaving the tail produces the result beat next cycle.
    a_tail_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_tok.live |=> o_valid && !busy)
        else $error("token left the chain without a result beat");

    // A slot write only follows a successful insert of a new route.
    a_place_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_en |-> o_valid && (o_status == ST_DONE))
        else $error("slot write without a successful insert");

    // A token only travels while a command is in progress.
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_live != '0) |-> busy)
        else $error("search token live while idle");
`endif

endmodule

// ===== tb/sv/lpm_route_table_tb.sv =====
// ----------------------------------------------------------------------------
// lpm_route_table_tb: self-checking bench for the LPM route table
// A clocked driver feeds insert, delete, lookup and unused-code commands from a queue.
// A clocked monitor checks every result beat against a behavioral copy of
// the table kept here.
// ----------------------------------------------------------------------------
module lpm_route_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrt_pkg::*;

    localparam int TABLE_DEPTH = LRT_TABLE_DEPTH;
    localparam int KEY_COUNT   = 48;
    localparam int RANDOM_CMDS = 450;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

    // One expected result beat.
    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    next_hop;
        logic [PORT_W-1:0]    port;
        logic [METRIC_W-1:0]  metric;
    } t_route_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_func = 2'd0;
    logic [ADDR_W-1:0]   i_prefix_addr = '0;
    logic [LEN_W-1:0]    i_prefix_len = '0;
    logic [PORT_W-1:0]   i_port = '0;
    logic [ADDR_W-1:0]   i_next_hop = '0;
    logic [METRIC_W-1:0] i_hop_metric = '0;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0]   o_out_next_hop;
    logic [PORT_W-1:0]   o_out_port;
    logic [METRIC_W-1:0] o_out_metric;

    // Commands waiting to be driven and results waiting to arrive.
    t_item         cmd_q[$];
    t_route_result result_q[$];

    // Shadow copy of the route table.
    logic                rt_valid  [TABLE_DEPTH] = '{default: 1'b0};
    logic [ADDR_W-1:0]   rt_prefix [TABLE_DEPTH];
    logic [LEN_W-1:0]    rt_len    [TABLE_DEPTH];
    logic [ADDR_W-1:0]   rt_nh     [TABLE_DEPTH];
    logic [PORT_W-1:0]   rt_port   [TABLE_DEPTH];
    logic [METRIC_W-1:0] rt_metric [TABLE_DEPTH];

    // Route keys that the random commands draw from.
    logic [ADDR_W-1:0] key_addr [KEY_COUNT];
    logic [LEN_W-1:0]  key_len  [KEY_COUNT];

    int n_total    = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int n_insert   = 0;
    int n_replace  = 0;
    int n_full     = 0;
    int n_delete   = 0;
    int n_removed  = 0;
    int n_lookup   = 0;
    int n_hit      = 0;
    int gap_cnt    = 0;
    int stall_cnt  = 0;

    lpm_route_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_prefix_addr  (i_prefix_addr),
        .i_prefix_len   (i_prefix_len),
        .i_port         (i_port),
        .i_next_hop     (i_next_hop),
        .i_hop_metric   (i_hop_metric),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_next_hop (o_out_next_hop),
        .o_out_port     (o_out_port),
        .o_out_metric   (o_out_metric)
    );

    // Ones over the low len bits of an address.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        if (len >= LEN_W'(ADDR_W)) begin
            return '1;
        end
        return ~({ADDR_W{1'b1}} << len);
    endfunction

    // Applies one command to the shadow table and returns its result beat.
    function automatic t_route_result route_table_apply(input t_item cmd);
        t_route_result     res;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  best_len;
        logic [ADDR_W-1:0] m;
        logic              found;
        int                slot;
        res.status   = ST_MISS;
        res.next_hop = '0;
        res.port     = '0;
        res.metric   = '0;
        len      = (cmd.len > FULL_LEN) ? FULL_LEN : cmd.len;
        best_len = '0;
        found    = 1'b0;
        slot     = -1;
        case (cmd.func)
            FN_INSERT: begin
                n_insert++;
                // An exact prefix and length match is replaced in place.
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot < 0 && rt_valid[i] && rt_prefix[i] == cmd.addr &&
                        rt_len[i] == len) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    n_replace++;
                end else begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot < 0 && !rt_valid[i]) begin
                            slot = i;
                        end
                    end
                end
                if (slot < 0) begin
                    res.status = ST_FULL;
                    n_full++;
                end else begin
                    rt_valid[slot]  = 1'b1;
                    rt_prefix[slot] = cmd.addr;
                    rt_len[slot]    = len;
                    rt_nh[slot]     = cmd.next_hop;
                    rt_port[slot]   = cmd.port;
                    rt_metric[slot] = cmd.metric;
                    res.status      = ST_DONE;
                end
            end
            FN_DELETE: begin
                n_delete++;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot < 0 && rt_valid[i] && rt_prefix[i] == cmd.addr &&
                        rt_len[i] == len) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    rt_valid[slot] = 1'b0;
                    res.status     = ST_DONE;
                    n_removed++;
                end
            end
            FN_LOOKUP: begin
                n_lookup++;
                // Only a strictly longer match displaces the current best,
                // so the lowest slot wins a tie.
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (rt_valid[i] && !(found && rt_len[i] <= best_len)) begin
                        m = prefix_mask(rt_len[i]);
                        if ((cmd.addr & m) == (rt_prefix[i] & m)) begin
                            found        = 1'b1;
                            best_len     = rt_len[i];
                            res.next_hop = rt_nh[i];
                            res.port     = rt_port[i];
                            res.metric   = rt_metric[i];
                        end
                    end
                end
                if (found) begin
                    res.status = ST_DONE;
                    n_hit++;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_cmd(input t_func f, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic [PORT_W-1:0] port,
                             input logic [ADDR_W-1:0] nh, input logic [METRIC_W-1:0] metric);
        t_item cmd;
        cmd.func     = f;
        cmd.addr     = addr;
        cmd.len      = len;
        cmd.port     = port;
        cmd.next_hop = nh;
        cmd.metric   = metric;
        cmd_q.insert(cmd_q.size(), cmd);
    endtask

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reset is held at the start of the run only.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Command driver: holds a beat until it is taken, then picks the next.
    always @(posedge i_clk) begin : cmd_driver
        logic  taken;
        logic  raise;
        int    hold;
        int    idle_pct;
        t_item nxt;
        if (!i_rst_n) begin
            start   <= 1'b0;
            gap_cnt <= 0;
        end else begin
            taken = start && !busy;
            hold  = gap_cnt;
            if (n_accepted < n_total / 3) begin
                idle_pct = 36;
            end else if (n_accepted < (2 * n_total) / 3) begin
                idle_pct = 72;
            end else begin
                idle_pct = 0;
            end
            if (taken) begin
                result_q.insert(result_q.size(), route_table_apply(cmd_q.pop_front()));
                n_accepted++;
                // A random gap moves the next beat across the busy window.
                if ($urandom_range(99) < idle_pct) begin
                    hold = $urandom_range(1, TABLE_DEPTH + 4);
                end
            end
            if (start && !taken) begin
                raise = 1'b1;
            end else if (hold > 0) begin
                raise = 1'b0;
                hold--;
            end else if (cmd_q.size() == 0) begin
                raise = 1'b0;
            end else begin
                raise = busy || ($urandom_range(99) >= idle_pct);
            end
            if (raise && !(start && !taken)) begin
                nxt = cmd_q[0];
                i_func        <= nxt.func;
                i_prefix_addr <= nxt.addr;
                i_prefix_len  <= nxt.len;
                i_port        <= nxt.port;
                i_next_hop    <= nxt.next_hop;
                i_hop_metric  <= nxt.metric;
            end
            start   <= raise;
            gap_cnt <= hold;
        end
    end

    // Result monitor: every beat must match the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_route_result exp_res;
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result beat status=%0d nh=%h port=%0d metric=%0d",
                         $time, o_status, o_out_next_hop, o_out_port, o_out_metric);
                n_errors++;
            end else begin
                exp_res = result_q.pop_front();
                if (o_status !== exp_res.status || o_out_next_hop !== exp_res.next_hop ||
                    o_out_port !== exp_res.port || o_out_metric !== exp_res.metric) begin
                    $display("%0t: mismatch expected status=%0d nh=%h port=%0d metric=%0d",
                             $time, exp_res.status, exp_res.next_hop, exp_res.port,
                             exp_res.metric);
                    $display("%0t:          actual   status=%0d nh=%h port=%0d metric=%0d",
                             $time, o_status, o_out_next_hop, o_out_port, o_out_metric);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither a command nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        t_item             cmd;
        logic [ADDR_W-1:0] bases [4];
        logic [ADDR_W-1:0] m;
        int                r;
        int                k;
        int                ins_w;
        int                del_w;

        // Empty table, then the default route with junk in its high bits.
        queue_cmd(FN_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0, 32'd0, 5'd0);
        queue_cmd(FN_INSERT, 32'hDEAD_BEEF, 6'd0, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(FN_LOOKUP, 32'h0000_0000, 6'd63, 8'd0, 32'd0, 5'd0);
        // Two routes of equal length that differ only above the prefix.
        queue_cmd(FN_INSERT, 32'h0000_000A, 6'd8, 8'd1, 32'd0, 5'd0);
        queue_cmd(FN_INSERT, 32'hFFFF_FF0A, 6'd8, 8'd2, 32'h0A00_0001, 5'd1);
        queue_cmd(FN_LOOKUP, 32'h1234_560A, 6'd0, 8'd0, 32'd0, 5'd0);
        // Length above 32 is clamped.
        queue_cmd(FN_INSERT, 32'h0101_A8C0, 6'd63, 8'd3, 32'hC0A8_0001, 5'd16);
        queue_cmd(FN_LOOKUP, 32'h0101_A8C0, 6'd0, 8'd0, 32'd0, 5'd0);
        queue_cmd(FN_LOOKUP, 32'h0201_A8C0, 6'd0, 8'd0, 32'd0, 5'd0);
        // Replacing insert, then delete hit, delete miss and a delete hit on a clamped length.
        queue_cmd(FN_INSERT, 32'h0000_000A, 6'd8, 8'd4, 32'h0102_0304, 5'd16);
        queue_cmd(FN_LOOKUP, 32'h0000_000A, 6'd0, 8'd0, 32'd0, 5'd0);
        queue_cmd(FN_DELETE, 32'h0000_000A, 6'd8, 8'd0, 32'd0, 5'd0);
        queue_cmd(FN_LOOKUP, 32'h0000_000A, 6'd0, 8'd0, 32'd0, 5'd0);
        queue_cmd(FN_DELETE, 32'h0000_000A, 6'd8, 8'd0, 32'd0, 5'd0);
        queue_cmd(FN_DELETE, 32'h0101_A8C0, 6'd40, 8'd0, 32'd0, 5'd0);
        // The unused operation code leaves the table alone.
        queue_cmd(FN_UNUSED, $urandom, 6'($urandom), 8'($urandom), $urandom, 5'($urandom));
        queue_cmd(FN_DELETE, 32'hDEAD_BEEF, 6'd0, 8'd0, 32'd0, 5'd0);
        queue_cmd(FN_LOOKUP, 32'h0000_0000, 6'd0, 8'd0, 32'd0, 5'd0);

        // Keys share a few network bases so that prefixes nest; key 0 is a
        // default route. Bits above each length are left random.
        for (int b = 0; b < 4; b++) begin
            bases[b] = $urandom;
        end
        for (int i = 0; i < KEY_COUNT; i++) begin
            key_len[i]  = (i == 0) ? 6'd0 : 6'($urandom_range(1, 32));
            m           = prefix_mask(key_len[i]);
            key_addr[i] = (bases[i % 4] & m) | ($urandom & ~m);
        end

        // Random part: insert-heavy so the table fills, then delete-heavy, then insert-heavy again.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            case ((3 * n) / RANDOM_CMDS)
                0: begin ins_w = 45; del_w = 10; end
                1: begin ins_w = 25; del_w = 30; end
                default: begin ins_w = 35; del_w = 12; end
            endcase
            r = $urandom_range(99);
            k = $urandom_range(KEY_COUNT - 1);
            cmd.addr     = key_addr[k];
            cmd.len      = key_len[k];
            cmd.port     = 8'($urandom);
            cmd.next_hop = $urandom;
            cmd.metric   = 5'($urandom);
            if (cmd.len == FULL_LEN && $urandom_range(1) == 1) begin
                cmd.len = 6'($urandom_range(33, 63));
            end
            if (r < ins_w) begin
                cmd.func = FN_INSERT;
            end else if (r < ins_w + del_w) begin
                cmd.func = FN_DELETE;
            end else if (r < 90) begin
                // Address inside the key's network, random elsewhere.
                m        = prefix_mask(cmd.len);
                cmd.func = FN_LOOKUP;
                cmd.addr = (key_addr[k] & m) | ($urandom & ~m);
                cmd.len  = 6'($urandom);
            end else begin
                cmd.func     = t_func'($urandom_range(3));
                cmd.addr     = $urandom;
                cmd.len      = 6'($urandom);
            end
            cmd_q.insert(cmd_q.size(), cmd);
        end
        n_total = cmd_q.size();

        // Wait for every beat to go through, then give the block time to
        // show any stray result.
        while (!i_rst_n || cmd_q.size() != 0 || start || result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: %0d inserts (%0d replaced, %0d on a full table),",
                 n_accepted, n_insert, n_replace, n_full);
        $display("  %0d deletes (%0d removed), %0d lookups (%0d matched), %0d errors.",
                 n_delete, n_removed, n_lookup, n_hit, n_errors);
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
